// ===== rtl/priority_key_stable_sorter_top_defines.svh =====
// Assertion macros shared by the checker of the priority key sorter.
// No dependencies; included by the checker file.
`ifndef PRIORITY_KEY_STABLE_SORTER_TOP_DEFINES_SVH
`define PRIORITY_KEY_STABLE_SORTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PKSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PKSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pkss_pkg.sv =====
// Shared types, record layout and sort key for the priority key sorter.
// No dependencies; used by the datapath, controller and top level.
`timescale 1ns / 1ps

package pkss_pkg;

    localparam int REC_W   = 26;
    localparam int TDATA_W = 32;
    localparam int RANK_W  = 10;

    // packed record: tag[15:0], pct[22:16], has_context[23], state[25:24]
    typedef logic [REC_W-1:0] rec_t;

    typedef struct packed {
        logic load;       // take the incoming request into the work register
        logic drop;       // store full: mark the set as overflowed
        logic shift;      // move the entry before the hole up by one
        logic place;      // write the new record into the hole
        logic emit_read;  // read the entry at the emit index
        logic emit_load;  // capture the read entry into the output register
        logic emit_next;  // advance the emit index
        logic finish;     // clear count, overflow flag and emit index
    } cmd_t;

    typedef struct packed {
        logic full;       // store holds the maximum number of records
        logic in_last;    // incoming request closes the set
        logic rec_last;   // record under insertion closes the set
        logic pos_zero;   // hole has reached the front of the store
        logic greater;    // entry before the hole ranks after the new record
        logic idx_last;   // emit index points at the final stored record
    } status_t;

    // Ascending rank: state, then context before none, then larger percent.
    function automatic logic [RANK_W-1:0] rank_of(input rec_t rec);
        rank_of = {rec[25:24], ~rec[23], ~rec[22:16]};
    endfunction

endpackage

// ===== rtl/pkss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pkss_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold the last read word when no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pkss_datapath.sv =====
// Datapath: record store, insertion hole pointer, count, emit index and
// output register. Depends on pkss_pkg and pkss_ram.
`timescale 1ns / 1ps

module pkss_datapath #(
    parameter int MAX_RECORDS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pkss_pkg::cmd_t                  cmd,
    output pkss_pkg::status_t               status,
    input  logic [pkss_pkg::TDATA_W-1:0]    in_data,
    input  logic                            in_last,
    output logic [pkss_pkg::TDATA_W-1:0]    out_data,
    output logic                            out_last,
    output logic                            out_overflow
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W = $clog2(MAX_RECORDS);

    pkss_pkg::rec_t     rec_reg;
    logic               rec_last_reg;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped_reg, dropped_next;
    logic [IDX_W-1:0]   emit_idx_reg, emit_idx_next;
    pkss_pkg::rec_t     out_rec_reg;
    logic               out_last_reg;
    logic               out_ovf_reg;

    pkss_pkg::rec_t     in_rec;
    pkss_pkg::rec_t     rd_data;
    pkss_pkg::rec_t     wr_data;
    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   count_m1;
    logic [CNT_W-1:0]   pos_m2;
    logic               full;

    // tdata: state[1:0], has_context[2], pct[9:3], tag[25:10]
    assign in_rec = {in_data[1:0], in_data[2], in_data[9:3], in_data[25:10]};

    assign full     = (count_reg == CNT_W'(MAX_RECORDS));
    assign count_m1 = count_reg - CNT_W'(1);
    assign pos_m2   = pos_reg - CNT_W'(2);

    assign status.full     = full;
    assign status.in_last  = in_last;
    assign status.rec_last = rec_last_reg;
    assign status.pos_zero = (pos_reg == '0);
    assign status.greater  = (pkss_pkg::rank_of(rd_data) > pkss_pkg::rank_of(rec_reg));
    assign status.idx_last = ((CNT_W'(emit_idx_reg) + CNT_W'(1)) == count_reg);

    // write side: a shift copies the entry before the hole, a place drops in
    // the new record
    assign wr_en   = cmd.shift | cmd.place;
    assign wr_data = cmd.shift ? rd_data : rec_reg;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = emit_idx_reg;
        if (cmd.load)
        begin
            rd_en   = !full && (count_reg != '0);
            rd_addr = count_m1[IDX_W-1:0];
        end
        else if (cmd.shift)
        begin
            rd_en   = (pos_reg >= CNT_W'(2));
            rd_addr = pos_m2[IDX_W-1:0];
        end
        else if (cmd.emit_read)
        begin
            rd_en   = 1'b1;
            rd_addr = emit_idx_reg;
        end
    end

    pkss_ram #(
        .WIDTH (pkss_pkg::REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (pos_reg[IDX_W-1:0]),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        pos_next      = pos_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        emit_idx_next = emit_idx_reg;
        if (cmd.load)
        begin
            pos_next = count_reg;
        end
        if (cmd.shift)
        begin
            pos_next = pos_reg - CNT_W'(1);
        end
        if (cmd.drop)
        begin
            dropped_next = 1'b1;
        end
        if (cmd.place)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.emit_next)
        begin
            emit_idx_next = emit_idx_reg + IDX_W'(1);
        end
        if (cmd.finish)
        begin
            count_next    = '0;
            dropped_next  = 1'b0;
            emit_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            emit_idx_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            emit_idx_reg <= emit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rec_reg      <= in_rec;
            rec_last_reg <= in_last;
        end
        if (cmd.emit_load)
        begin
            out_rec_reg  <= rd_data;
            out_last_reg <= status.idx_last;
            out_ovf_reg  <= dropped_reg;
        end
    end

    assign out_data = {{(pkss_pkg::TDATA_W - pkss_pkg::REC_W){1'b0}},
                       out_rec_reg[15:0], out_rec_reg[22:16],
                       out_rec_reg[23], out_rec_reg[25:24]};
    assign out_last     = out_last_reg;
    assign out_overflow = out_ovf_reg;

endmodule

// ===== rtl/pkss_ctrl.sv =====
// Controller: sequences loading, insertion walk and emission of the sorted set.
// Depends on pkss_pkg.
`timescale 1ns / 1ps

module pkss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pkss_pkg::status_t   status,
    output pkss_pkg::cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_EMIT_RD = 2'd2;
    localparam logic [1:0] ST_EMIT_LD = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.full)
                    begin
                        cmd.drop = 1'b1;
                        if (status.in_last)
                        begin
                            state_next = ST_EMIT_RD;
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // walk down while the stored entry ranks strictly after the new one
                if (status.pos_zero || !status.greater)
                begin
                    cmd.place  = 1'b1;
                    state_next = status.rec_last ? ST_EMIT_RD : ST_IDLE;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.idx_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/priority_key_stable_sorter_top.sv =====
// Channel  Dir  Signals                         Meaning
// s        in   s_tvalid s_tready s_tdata s_tlast  one record request, tlast closes the set
// m        out  m_tvalid m_tready m_tdata m_tlast  sorted records, tlast on final one
//                  m_tuser                         overflow flag of the run
//
// A record inserted into the store is accepted, then walks down with one RAM
// read-compare-write step per entry walked, and is then placed in the hole.
// Emission reads each record from the RAM, then loads it into the output register;
// the output register lets the next set load while the last result waits.
// Asynchronous active-low reset clears count, overflow flag and control; the
// store needs no clearing. m_tready low holds a pending result and emission.
// Depends on pkss_pkg, pkss_ctrl, pkss_datapath.
`timescale 1ns / 1ps

module priority_key_stable_sorter_top #(
    parameter int MAX_RECORDS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // agent_state[1:0], has_context[2], context_pct[9:3], agent_tag[25:10], zero[31:26]
    input  logic [pkss_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_state[1:0], out_has_context[2], out_context_pct[9:3], out_tag[25:10], zero[31:26]
    output logic [pkss_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tlast,
    // overflow[0]
    output logic                          m_tuser
);

    pkss_pkg::cmd_t    cmd;
    pkss_pkg::status_t status;

    pkss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    pkss_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_data      (s_tdata),
        .in_last      (s_tlast),
        .out_data     (m_tdata),
        .out_last     (m_tlast),
        .out_overflow (m_tuser)
    );

endmodule

// ===== rtl/pkss_checker.sv =====
// Port-level checks for the priority key sorter, bound to the top level.
// Depends on pkss_pkg and priority_key_stable_sorter_top_defines.svh.
`timescale 1ns / 1ps
`include "priority_key_stable_sorter_top_defines.svh"

module pkss_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [pkss_pkg::TDATA_W-1:0]  m_tdata,
    input  logic                          m_tlast,
    input  logic                          m_tuser
);

    // a stalled result keeps its payload
    `PKSS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

    // a request that closes the set starts emission, so loading pauses
    `PKSS_ASSERT_NEXT(a_last_blocks, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready, "input still open after final record")

    // padding above the record stays clear
    `PKSS_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[pkss_pkg::TDATA_W-1:pkss_pkg::REC_W] == '0, "nonzero padding on result")

endmodule

bind priority_key_stable_sorter_top pkss_checker u_pkss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== sim/priority_key_stable_sorter_top_tb.sv =====
// Self-checking testbench for the priority key stable sorter: stable composite-key order,
// store overflow and end-of-set handling, checked against an in-bench insertion predictor.
// Depends on pkss_pkg and priority_key_stable_sorter_top.
`timescale 1ns / 1ps

module priority_key_stable_sorter_top_tb;

    localparam int MAX_RECORDS   = 32;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 4 * MAX_RECORDS;
    localparam int RES_DEPTH     = 256;

    localparam logic [1:0] ST_BLOCKED = 2'd0;
    localparam logic [1:0] ST_WORKING = 2'd1;
    localparam logic [1:0] ST_IDLE    = 2'd2;
    localparam logic [1:0] ST_OTHER   = 2'd3;

    typedef struct packed {
        logic [1:0]  state;
        logic        has_ctx;
        logic [6:0]  pct;
        logic [15:0] tag;
    } agent_rec_t;

    typedef struct {
        agent_rec_t rec;
        logic       last;
        logic       ovf;
    } sorted_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [pkss_pkg::TDATA_W-1:0]  s_tdata = '0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pkss_pkg::TDATA_W-1:0]  m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;

    int src_idle_pct  = 33;
    int sink_stall_pct = 60;

    // predictor state: the set under collection, kept sorted
    agent_rec_t     held_set [MAX_RECORDS];
    int             held_count = 0;
    logic           set_dropped = 1'b0;

    // expected results in order, as a ring with write and read counts
    sorted_result_t results_buf [RES_DEPTH];
    int             res_wr = 0;
    int             res_rd = 0;

    int records_sent   = 0;
    int sets_closed    = 0;
    int overflow_sets  = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    priority_key_stable_sorter_top #(
        .MAX_RECORDS(MAX_RECORDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Lower number sorts earlier: state, then context before none, then larger percent.
    function automatic int sort_weight(input agent_rec_t r);
        return int'(r.state) * 256 + (r.has_ctx ? 0 : 128) + (127 - int'(r.pct));
    endfunction

    function automatic void insert_record(input agent_rec_t r, input logic last);
        int pos;
        sorted_result_t res;
        if (held_count < MAX_RECORDS)
        begin
            pos = held_count;
            while (pos > 0 && sort_weight(held_set[pos-1]) > sort_weight(r))
            begin
                held_set[pos] = held_set[pos-1];
                pos--;
            end
            held_set[pos] = r;
            held_count++;
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (last)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                res.rec  = held_set[i];
                res.last = (i == held_count - 1);
                res.ovf  = set_dropped;
                results_buf[res_wr % RES_DEPTH] = res;
                res_wr++;
            end
            sets_closed++;
            if (set_dropped)
                overflow_sets++;
            held_count  = 0;
            set_dropped = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string field, input int exp_v, input int act_v);
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, exp_v, act_v);
        error_count++;
    endtask

    task automatic send_record(input agent_rec_t r, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(pkss_pkg::TDATA_W-pkss_pkg::REC_W){1'b0}},
                     r.tag, r.pct, r.has_ctx, r.state};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        records_sent++;
    endtask

    // Record every accepted request in the predictor.
    always @(posedge clk)
    begin : request_monitor
        agent_rec_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            r.state   = s_tdata[1:0];
            r.has_ctx = s_tdata[2];
            r.pct     = s_tdata[9:3];
            r.tag     = s_tdata[25:10];
            insert_record(r, s_tlast);
        end
    end

    always @(posedge clk)
    begin : result_check
        sorted_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (res_rd == res_wr)
            begin
                $display("%0t: unexpected result, expected none, actual tdata=%h tlast=%b tuser=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                error_count++;
            end
            else
            begin
                want = results_buf[res_rd % RES_DEPTH];
                res_rd++;
                if (m_tdata[1:0] !== want.rec.state)
                    report_mismatch("out_state", want.rec.state, m_tdata[1:0]);
                if (m_tdata[2] !== want.rec.has_ctx)
                    report_mismatch("out_has_context", want.rec.has_ctx, m_tdata[2]);
                if (m_tdata[9:3] !== want.rec.pct)
                    report_mismatch("out_context_pct", want.rec.pct, m_tdata[9:3]);
                if (m_tdata[25:10] !== want.rec.tag)
                    report_mismatch("out_tag", want.rec.tag, m_tdata[25:10]);
                if (m_tlast !== want.last)
                    report_mismatch("last_out", want.last, m_tlast);
                if (m_tuser !== want.ovf)
                    report_mismatch("overflow", want.ovf, m_tuser);
            end
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // End the run if neither side moves a request for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, res_wr - res_rd);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Field extremes, every state, context on and off, percent above 100, full ties.
    task automatic test_key_order();
        agent_rec_t mixed [12];
        mixed[0]  = '{ST_OTHER,   1'b0, 7'd0,   16'h0001};
        mixed[1]  = '{ST_IDLE,    1'b1, 7'd100, 16'h0002};
        mixed[2]  = '{ST_WORKING, 1'b0, 7'd127, 16'h0003};
        mixed[3]  = '{ST_BLOCKED, 1'b1, 7'd0,   16'h0004};
        mixed[4]  = '{ST_BLOCKED, 1'b0, 7'd100, 16'h0005};
        mixed[5]  = '{ST_WORKING, 1'b1, 7'd50,  16'h0006};
        mixed[6]  = '{ST_BLOCKED, 1'b1, 7'd0,   16'h0007};
        mixed[7]  = '{ST_IDLE,    1'b1, 7'd100, 16'h0008};
        mixed[8]  = '{ST_OTHER,   1'b1, 7'd127, 16'h0009};
        mixed[9]  = '{ST_BLOCKED, 1'b0, 7'd127, 16'hFFFF};
        mixed[10] = '{ST_WORKING, 1'b0, 7'd5,   16'h0000};
        mixed[11] = '{ST_IDLE,    1'b0, 7'd0,   16'hA5A5};
        foreach (mixed[i])
            send_record(mixed[i], i == 11);
        // one-record set
        send_record('{ST_OTHER, 1'b1, 7'd127, 16'hFFFF}, 1'b1);
        // identical keys must come out in arrival order
        send_record('{ST_WORKING, 1'b1, 7'd64, 16'h1234}, 1'b0);
        send_record('{ST_WORKING, 1'b1, 7'd64, 16'h4321}, 1'b1);
    endtask

    // Exactly full, then overfull with the trailing records dropped, the closing one among them.
    task automatic test_store_full();
        agent_rec_t r;
        for (int pass = 0; pass < 2; pass++)
        begin
            for (int k = 0; k < MAX_RECORDS + 3 * pass; k++)
            begin
                r.state   = 2'($urandom_range(0, 3));
                r.has_ctx = 1'($urandom_range(0, 1));
                r.pct     = 7'($urandom_range(0, 2) * 50);
                r.tag     = 16'($urandom);
                send_record(r, k == MAX_RECORDS + 3 * pass - 1);
            end
        end
    endtask

    // Mostly small sets, some large, a few past capacity; keys often collide.
    task automatic test_random_sets(input int n_items);
        int sent;
        int set_len;
        int pick;
        agent_rec_t r;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                set_len = $urandom_range(1, 8);
            else if (pick < 95)
                set_len = $urandom_range(9, MAX_RECORDS);
            else
                set_len = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
            for (int k = 0; k < set_len; k++)
            begin
                r.state   = 2'($urandom_range(0, 3));
                r.has_ctx = 1'($urandom_range(0, 1));
                pick      = $urandom_range(0, 99);
                if (pick < 70)
                    r.pct = 7'($urandom_range(0, 100));
                else if (pick < 85)
                    r.pct = 7'($urandom_range(0, 127));
                else
                    r.pct = 7'($urandom_range(0, 2) * 50);
                r.tag = 16'($urandom);
                send_record(r, k == set_len - 1);
            end
            sent += set_len;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct   = 33;
        sink_stall_pct = 60;
        test_key_order();
        test_store_full();
        test_random_sets(37);

        src_idle_pct   = 60;
        sink_stall_pct = 33;
        test_random_sets(37);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_sets(37);
        test_store_full();

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (res_rd != res_wr)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d records in %0d sets (%0d past capacity), checked %0d sorted results",
                 records_sent, sets_closed, overflow_sets, results_seen);
        $display("under three pacing modes: slow source, slow sink, and full rate.");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
